// ===== rtl/led_matrix_chain_frame_builder_unit_macros.svh =====
// Assertion macros used by the frame builder back end RTL.
`ifndef LED_MATRIX_CHAIN_FRAME_BUILDER_UNIT_MACROS_SVH
`define LED_MATRIX_CHAIN_FRAME_BUILDER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define LMCFB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define LMCFB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LMCFB_ASSERT_IMP(lbl, ante, cons, msg)
`define LMCFB_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/lmcfb_pkg.sv =====
// Shared types, constants and start-up tables of the LED matrix frame builder.
package lmcfb_pkg;

  localparam int MAX_CHIPS   = 4;
  localparam int SLOTS       = 4;
  localparam int LIM_RAW     = (MAX_CHIPS < SLOTS) ? MAX_CHIPS : SLOTS;
  localparam int LIM_CHIPS   = (LIM_RAW < 1) ? 1 : LIM_RAW;
  localparam int STORE_DEPTH = 32;
  localparam int CMDQ_DEPTH  = 2;
  localparam int INIT_STEPS  = 5;

  localparam logic [2:0] REQ_SET_PIXEL   = 3'd0;
  localparam logic [2:0] REQ_CLEAR_PIXEL = 3'd1;
  localparam logic [2:0] REQ_SET_COLUMN  = 3'd2;
  localparam logic [2:0] REQ_COMMIT      = 3'd3;
  localparam logic [2:0] REQ_DEVICE      = 3'd4;
  localparam logic [2:0] REQ_BROADCAST   = 3'd5;
  localparam logic [2:0] REQ_INIT        = 3'd6;

  localparam logic [3:0] REG_DECODE_MODE  = 4'h9;
  localparam logic [3:0] REG_INTENSITY    = 4'hA;
  localparam logic [3:0] REG_SCAN_LIMIT   = 4'hB;
  localparam logic [3:0] REG_SHUTDOWN     = 4'hC;
  localparam logic [3:0] REG_DISPLAY_TEST = 4'hF;

  typedef enum logic [2:0] {
    CMD_WRITE,
    CMD_SET,
    CMD_CLEAR,
    CMD_COMMIT,
    CMD_DEVICE,
    CMD_BCAST,
    CMD_INIT
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [4:0] addr;
    logic [7:0] data;
    logic [1:0] dev;
    logic [3:0] reg_addr;
  } cmd_t;

  function automatic logic [3:0] init_reg(input logic [2:0] step);
    logic [3:0] r;
    case (step)
      3'd0:    r = REG_SCAN_LIMIT;
      3'd1:    r = REG_DECODE_MODE;
      3'd2:    r = REG_DISPLAY_TEST;
      3'd3:    r = REG_INTENSITY;
      default: r = REG_SHUTDOWN;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] init_val(input logic [2:0] step);
    logic [7:0] v;
    case (step)
      3'd0:    v = 8'd7;
      3'd4:    v = 8'd1;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/lmcfb_front.sv =====
// Front end: chain length register, request acceptance and classification.
module lmcfb_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic [2:0]            req_type,
  input  logic [4:0]            pixel_x,
  input  logic [2:0]            pixel_y,
  input  logic [4:0]            column_index,
  input  logic [7:0]            data_byte,
  input  logic [1:0]            device_index,
  input  logic [3:0]            reg_addr,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_data,
  input  logic                  q_full,
  output logic                  q_push,
  output lmcfb_pkg::cmd_t       q_cmd,
  output logic [2:0]            n_chips
);
  import lmcfb_pkg::*;

  localparam logic [2:0] LIM_N = 3'(LIM_CHIPS);

  logic [2:0] chain_length;
  logic       keep;

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_length <= 3'd1;
    end else if (cfg_valid) begin
      chain_length <= cfg_data;
    end
  end

  assign cfg_ready = 1'b1;

  always_comb begin
    if (chain_length == 3'd0) begin
      n_chips = 3'd1;
    end else if (chain_length > LIM_N) begin
      n_chips = LIM_N;
    end else begin
      n_chips = chain_length;
    end
  end

  // requests that address beyond the chain are dropped here
  always_comb begin
    q_cmd.op       = CMD_COMMIT;
    q_cmd.addr     = column_index;
    q_cmd.data     = data_byte;
    q_cmd.dev      = device_index;
    q_cmd.reg_addr = reg_addr;
    keep           = 1'b0;
    case (req_type)
      REQ_SET_PIXEL, REQ_CLEAR_PIXEL: begin
        keep       = {1'b0, pixel_x[4:3]} < n_chips;
        q_cmd.op   = (req_type == REQ_SET_PIXEL) ? CMD_SET : CMD_CLEAR;
        q_cmd.addr = {pixel_x[4:3], ~pixel_y};
        q_cmd.data = 8'h80 >> pixel_x[2:0];
      end
      REQ_SET_COLUMN: begin
        keep     = {1'b0, column_index[4:3]} < n_chips;
        q_cmd.op = CMD_WRITE;
      end
      REQ_COMMIT: begin
        keep     = 1'b1;
        q_cmd.op = CMD_COMMIT;
      end
      REQ_DEVICE: begin
        keep     = {1'b0, device_index} < n_chips;
        q_cmd.op = CMD_DEVICE;
      end
      REQ_BROADCAST: begin
        keep     = 1'b1;
        q_cmd.op = CMD_BCAST;
      end
      REQ_INIT: begin
        keep     = 1'b1;
        q_cmd.op = CMD_INIT;
      end
      default: keep = 1'b0;
    endcase
  end

  assign full   = q_full;
  assign q_push = push && !q_full && keep;

endmodule

// ===== rtl/lmcfb_cmdq.sv =====
// Short command queue between the front end and the frame sequencer.
module lmcfb_cmdq (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lmcfb_pkg::cmd_t din,
  output logic            full,
  input  logic            pop,
  output lmcfb_pkg::cmd_t dout,
  output logic            empty
);
  import lmcfb_pkg::*;

  localparam int PW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CW = $clog2(CMDQ_DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(CMDQ_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(CMDQ_DEPTH);

  cmd_t          slots [CMDQ_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CNT_FULL);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/lmcfb_back.sv =====
// Back end: column store, command sequencer and output frame register.
`include "led_matrix_chain_frame_builder_unit_macros.svh"
module lmcfb_back (
  input  logic            clk,
  input  logic            rst,
  input  logic [2:0]      n_chips,
  input  logic            q_empty,
  input  lmcfb_pkg::cmd_t q_cmd,
  output logic            q_pop,
  input  logic            pop,
  output logic            empty,
  output logic [15:0]     slot0_word,
  output logic [15:0]     slot1_word,
  output logic [15:0]     slot2_word,
  output logic [15:0]     slot3_word,
  output logic            last_frame
);
  import lmcfb_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);
  localparam logic [2:0] STEP_LAST = 3'(INIT_STEPS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MODIFY,
    S_CREAD,
    S_CEMIT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0] dev;
    logic [3:0] reg_addr;
    logic [7:0] data;
    logic       last;
  } frame_t;

  state_t           state;
  cmd_t             cmd;
  logic [AW-1:0]    cnt;
  logic [1:0]       dcnt;
  logic [2:0]       step;
  logic             out_valid;
  frame_t           out_frame;
  frame_t           frame_next;
  logic             out_load;
  logic             out_free;
  logic [1:0]       nm1;

  logic [7:0]       mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] vld;
  logic [7:0]       rd_data;
  logic             rd_vld;
  logic [7:0]       rdat;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [7:0]       wdata;
  logic [AW-1:0]    raddr;

  assign nm1      = 2'(n_chips - 3'd1);
  assign out_free = !out_valid || pop;
  assign rdat     = rd_vld ? rd_data : 8'h00;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[raddr];
  end

  // never-written columns read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      rd_vld <= vld[raddr];
    end
  end

  always_comb begin
    q_pop      = 1'b0;
    we         = 1'b0;
    waddr      = cmd.addr;
    wdata      = 8'h00;
    raddr      = q_cmd.addr;
    out_load   = 1'b0;
    frame_next = '0;
    case (state)
      S_IDLE: begin
        q_pop = !q_empty;
        if (!q_empty && q_cmd.op == CMD_WRITE) begin
          we    = 1'b1;
          waddr = q_cmd.addr;
          wdata = q_cmd.data;
        end
      end
      S_MODIFY: begin
        we    = 1'b1;
        wdata = (cmd.op == CMD_SET) ? (rdat | cmd.data) : (rdat & ~cmd.data);
      end
      S_CREAD: raddr = cnt;
      S_CEMIT: begin
        // read one column ahead so a frame can leave every cycle while the output is free
        raddr               = out_free ? cnt + 1'b1 : cnt;
        out_load            = out_free;
        frame_next.dev      = cnt[AW-1:3];
        frame_next.reg_addr = 4'(cnt[2:0]) + 4'd1;
        frame_next.data     = rdat;
        frame_next.last     = (cnt[AW-1:3] == nm1) && (cnt[2:0] == 3'd7);
      end
      S_EMIT: begin
        out_load = out_free;
        case (cmd.op)
          CMD_DEVICE: begin
            frame_next = '{dev: cmd.dev, reg_addr: cmd.reg_addr, data: cmd.data,
                           last: 1'b1};
          end
          CMD_BCAST: begin
            frame_next = '{dev: dcnt, reg_addr: cmd.reg_addr, data: cmd.data,
                           last: dcnt == nm1};
          end
          default: begin
            frame_next = '{dev: dcnt, reg_addr: init_reg(step), data: init_val(step),
                           last: (dcnt == nm1) && (step == STEP_LAST)};
          end
        endcase
      end
      default: q_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
        out_frame <= frame_next;
      end
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            cmd  <= q_cmd;
            cnt  <= '0;
            step <= '0;
            dcnt <= (q_cmd.op == CMD_DEVICE) ? q_cmd.dev : 2'd0;
            case (q_cmd.op)
              CMD_WRITE:           state <= S_IDLE;
              CMD_SET, CMD_CLEAR:  state <= S_MODIFY;
              CMD_COMMIT:          state <= S_CREAD;
              default:             state <= S_EMIT;
            endcase
          end
        end
        S_MODIFY: state <= S_IDLE;
        S_CREAD:  state <= S_CEMIT;
        S_CEMIT: begin
          if (out_free) begin
            if (frame_next.last) begin
              state <= S_IDLE;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            if (frame_next.last) begin
              state <= S_IDLE;
            end else if (cmd.op == CMD_INIT && step != STEP_LAST) begin
              step <= step + 3'd1;
            end else begin
              step <= '0;
              dcnt <= dcnt + 2'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign empty      = !out_valid;
  assign last_frame = out_frame.last;
  assign slot0_word = (out_frame.dev == 2'd0) ? {4'h0, out_frame.reg_addr, out_frame.data} : 16'h0;
  assign slot1_word = (out_frame.dev == 2'd1) ? {4'h0, out_frame.reg_addr, out_frame.data} : 16'h0;
  assign slot2_word = (out_frame.dev == 2'd2) ? {4'h0, out_frame.reg_addr, out_frame.data} : 16'h0;
  assign slot3_word = (out_frame.dev == 2'd3) ? {4'h0, out_frame.reg_addr, out_frame.data} : 16'h0;

  `LMCFB_ASSERT_IMP(a_load_free, out_load, !out_valid || pop, "pending frame overwritten")
  `LMCFB_ASSERT_NXT(a_modify_done, state == S_MODIFY, state == S_IDLE, "pixel update overran")
  `LMCFB_ASSERT_IMP(a_write_state, we, state == S_IDLE || state == S_MODIFY,
                    "column store written during frame output")
  `LMCFB_ASSERT_NXT(a_last_idle, out_load && frame_next.last, state == S_IDLE,
                    "sequencer busy after final frame")

endmodule

// ===== rtl/led_matrix_chain_frame_builder_unit.sv =====
// Top level of the LED matrix daisy chain frame builder.
// Requests enter through push/full: one is taken at an edge with push high and full low.
// Frames leave through empty/pop: the oldest frame sits on slot0..slot3_word and
// last_frame while empty is low and is taken at an edge with pop high.
// The chain length register is written on cfg_valid/cfg_ready (ready is always high).
// A front end classifies each request, drops those that address beyond the chain, and
// places it in a two-entry command queue; a sequencer then carries it out.
// In the sequencer a set column request is written from the idle state, a set or clear
// pixel is a read-modify-write of the column store, whose read port is registered, and
// device write, broadcast, init and commit send frames to the n chips in the chain.
// Frames come out at one per cycle while pop is held; the single output register and
// the column store read port set that figure.
// When pop stays low the sequencer holds its place and the queue fills, then full rises.
// Reset empties queue and output, sets the chain length to 1 and marks every column
// blank through per-column valid bits, so no clearing pass is needed.
module led_matrix_chain_frame_builder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  req_type,
  input  logic [4:0]  pixel_x,
  input  logic [2:0]  pixel_y,
  input  logic [4:0]  column_index,
  input  logic [7:0]  data_byte,
  input  logic [1:0]  device_index,
  input  logic [3:0]  reg_addr,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_data,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] slot0_word,
  output logic [15:0] slot1_word,
  output logic [15:0] slot2_word,
  output logic [15:0] slot3_word,
  output logic        last_frame
);
  import lmcfb_pkg::*;

  cmd_t       fq_cmd;
  cmd_t       qb_cmd;
  logic       fq_push;
  logic       fq_full;
  logic       qb_pop;
  logic       qb_empty;
  logic [2:0] n_chips;

  lmcfb_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .req_type     (req_type),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .column_index (column_index),
    .data_byte    (data_byte),
    .device_index (device_index),
    .reg_addr     (reg_addr),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .q_full       (fq_full),
    .q_push       (fq_push),
    .q_cmd        (fq_cmd),
    .n_chips      (n_chips)
  );

  lmcfb_cmdq u_cmdq (
    .clk   (clk),
    .rst   (rst),
    .push  (fq_push),
    .din   (fq_cmd),
    .full  (fq_full),
    .pop   (qb_pop),
    .dout  (qb_cmd),
    .empty (qb_empty)
  );

  lmcfb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .n_chips    (n_chips),
    .q_empty    (qb_empty),
    .q_cmd      (qb_cmd),
    .q_pop      (qb_pop),
    .pop        (pop),
    .empty      (empty),
    .slot0_word (slot0_word),
    .slot1_word (slot1_word),
    .slot2_word (slot2_word),
    .slot3_word (slot3_word),
    .last_frame (last_frame)
  );

endmodule

// ===== sim/tb_led_matrix_chain_frame_builder_unit.sv =====
// Self-checking testbench for the LED matrix daisy chain frame builder.
`timescale 1ns / 100ps

module tb_led_matrix_chain_frame_builder_unit;
  import lmcfb_pkg::*;

  localparam logic [2:0] REQ_UNUSED = 3'd7;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [2:0] op;
    logic [4:0] x;
    logic [2:0] y;
    logic [4:0] col;
    logic [7:0] data;
    logic [1:0] dev;
    logic [3:0] raddr;
  } chain_req_t;

  typedef struct packed {
    logic [3:0][15:0] word;
    logic             last;
  } chain_frame_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [2:0]  req_type = '0;
  logic [4:0]  pixel_x = '0;
  logic [2:0]  pixel_y = '0;
  logic [4:0]  column_index = '0;
  logic [7:0]  data_byte = '0;
  logic [1:0]  device_index = '0;
  logic [3:0]  reg_addr = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_data = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [15:0] slot0_word, slot1_word, slot2_word, slot3_word;
  logic        last_frame;

  // shadow of the block state
  logic [7:0]   column_shadow [STORE_DEPTH];
  logic [2:0]   chain_setting;
  chain_frame_t frame_q [$];

  bit tx_idle = 1'b0;
  bit rx_idle = 1'b0;
  int hold_left = 0;
  int n_errors = 0;
  int n_reqs = 0;
  int n_ignored = 0;
  int n_frames = 0;
  int n_settings = 0;
  int n_full_cycles = 0;

  led_matrix_chain_frame_builder_unit dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .req_type(req_type), .pixel_x(pixel_x), .pixel_y(pixel_y),
    .column_index(column_index), .data_byte(data_byte),
    .device_index(device_index), .reg_addr(reg_addr),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .empty(empty), .pop(pop),
    .slot0_word(slot0_word), .slot1_word(slot1_word),
    .slot2_word(slot2_word), .slot3_word(slot3_word),
    .last_frame(last_frame)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int active_chips();
    int n;
    n = int'(chain_setting);
    if (n < 1) n = 1;
    if (n > LIM_CHIPS) n = LIM_CHIPS;
    return n;
  endfunction

  function automatic void queue_frame(int dev, logic [3:0] raddr, logic [7:0] data,
                                      bit last);
    chain_frame_t f;
    f = '0;
    f.word[dev] = {4'h0, raddr, data};
    f.last = last;
    frame_q.push_back(f);
  endfunction

  // Updates the shadow state and queues the frames a request causes.
  // Returns 0 when the block has to ignore the request.
  function automatic bit apply_request(chain_req_t r);
    int n, ncols, c, b;
    logic [3:0] init_regs [INIT_STEPS];
    logic [7:0] init_vals [INIT_STEPS];
    init_regs = '{REG_SCAN_LIMIT, REG_DECODE_MODE, REG_DISPLAY_TEST, REG_INTENSITY,
                  REG_SHUTDOWN};
    init_vals = '{8'd7, 8'd0, 8'd0, 8'd0, 8'd1};
    n = active_chips();
    ncols = 8 * n;
    case (r.op)
      REQ_SET_PIXEL, REQ_CLEAR_PIXEL: begin
        if (int'(r.x) >= ncols) return 1'b0;
        // rotated mapping: row picks the column, x picks the bit
        c = (7 - int'(r.y)) + (int'(r.x) / 8) * 8;
        b = 7 - (int'(r.x) % 8);
        if (r.op == REQ_SET_PIXEL) column_shadow[c][b] = 1'b1;
        else column_shadow[c][b] = 1'b0;
      end
      REQ_SET_COLUMN: begin
        if (int'(r.col) >= ncols) return 1'b0;
        column_shadow[r.col] = r.data;
      end
      REQ_COMMIT: begin
        for (c = 0; c < ncols; c++)
          queue_frame(c / 8, 4'((c % 8) + 1), column_shadow[c], c == ncols - 1);
      end
      REQ_DEVICE: begin
        if (int'(r.dev) >= n) return 1'b0;
        queue_frame(int'(r.dev), r.raddr, r.data, 1'b1);
      end
      REQ_BROADCAST: begin
        for (c = 0; c < n; c++) queue_frame(c, r.raddr, r.data, c == n - 1);
      end
      REQ_INIT: begin
        for (c = 0; c < n; c++)
          for (b = 0; b < INIT_STEPS; b++)
            queue_frame(c, init_regs[b], init_vals[b], c == n - 1 && b == INIT_STEPS - 1);
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic chain_req_t mk_req(logic [2:0] op, logic [4:0] x, logic [2:0] y,
                                        logic [4:0] col, logic [7:0] data,
                                        logic [1:0] dev, logic [3:0] raddr);
    chain_req_t r;
    r = '{op, x, y, col, data, dev, raddr};
    return r;
  endfunction

  // Random content; indices mostly land inside the current chain.
  function automatic chain_req_t rand_req(logic [2:0] op);
    chain_req_t r;
    logic [31:0] raw;
    int n;
    n = active_chips();
    raw = $urandom;
    r = raw[$bits(chain_req_t)-1:0];
    r.op = op;
    if ($urandom_range(0, 99) < 85) begin
      r.x = 5'($urandom_range(0, 8 * n - 1));
      r.col = 5'($urandom_range(0, 8 * n - 1));
      r.dev = 2'($urandom_range(0, n - 1));
    end
    return r;
  endfunction

  function automatic logic [2:0] pick_op();
    int p;
    p = $urandom_range(0, 99);
    if (p < 18) return REQ_SET_PIXEL;
    if (p < 30) return REQ_CLEAR_PIXEL;
    if (p < 45) return REQ_SET_COLUMN;
    if (p < 62) return REQ_COMMIT;
    if (p < 75) return REQ_DEVICE;
    if (p < 87) return REQ_BROADCAST;
    if (p < 95) return REQ_INIT;
    return REQ_UNUSED;
  endfunction

  // push is not lowered at the end of a request, so back-to-back requests keep it
  // high; with tx_idle set a random idle gap may lower it before the next request
  task automatic send_req(input chain_req_t r, output bit effective);
    if (tx_idle && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    push <= 1'b1;
    req_type <= r.op;
    pixel_x <= r.x;
    pixel_y <= r.y;
    column_index <= r.col;
    data_byte <= r.data;
    device_index <= r.dev;
    reg_addr <= r.raddr;
    @(posedge clk);
    while (full) begin
      n_full_cycles++;
      @(posedge clk);
    end
    effective = apply_request(r);
    n_reqs++;
    if (!effective) n_ignored++;
  endtask

  task automatic send_list(input chain_req_t reqs [$]);
    bit eff;
    foreach (reqs[i]) send_req(reqs[i], eff);
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (frame_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_chain_length(input logic [2:0] value);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    chain_setting = value;
    n_settings++;
  endtask

  // Reset values: one chip, blank framebuffer.
  task automatic test_reset_state();
    send_list('{
      mk_req(REQ_COMMIT, 0, 0, 0, 0, 0, 0),
      mk_req(REQ_INIT, 0, 0, 0, 0, 0, 0),
      mk_req(REQ_BROADCAST, 0, 0, 0, 8'hFF, 0, 4'hF),
      mk_req(REQ_DEVICE, 0, 0, 0, 8'hAA, 0, 4'hF),
      mk_req(REQ_DEVICE, 0, 0, 0, 8'h55, 1, 4'h3),
      mk_req(REQ_SET_PIXEL, 5'd8, 0, 0, 0, 0, 0)});
    wait_idle();
  endtask

  task automatic test_directed();
    write_chain_length(3'd4);
    send_list('{
      mk_req(REQ_SET_PIXEL, 5'd0, 3'd0, 0, 0, 0, 0),
      mk_req(REQ_SET_PIXEL, 5'd31, 3'd7, 0, 0, 0, 0),
      mk_req(REQ_SET_PIXEL, 5'd7, 3'd0, 0, 0, 0, 0),
      mk_req(REQ_CLEAR_PIXEL, 5'd0, 3'd0, 0, 0, 0, 0),
      mk_req(REQ_SET_COLUMN, 0, 0, 5'd0, 8'hFF, 0, 0),
      mk_req(REQ_SET_COLUMN, 0, 0, 5'd31, 8'hA5, 0, 0),
      mk_req(REQ_SET_COLUMN, 0, 0, 5'd5, 8'h00, 0, 0),
      mk_req(REQ_DEVICE, 0, 0, 0, 8'hFF, 2'd3, 4'hF),
      mk_req(REQ_DEVICE, 0, 0, 0, 8'h00, 2'd0, 4'h0),
      mk_req(REQ_BROADCAST, 0, 0, 0, 8'h00, 0, 4'h0),
      mk_req(REQ_INIT, 0, 0, 0, 0, 0, 0),
      mk_req(REQ_UNUSED, 5'd31, 3'd7, 5'd31, 8'hFF, 2'd3, 4'hF),
      mk_req(REQ_COMMIT, 0, 0, 0, 0, 0, 0)});
    wait_idle();
    // indices past a two-chip chain are dropped
    write_chain_length(3'd2);
    send_list('{
      mk_req(REQ_SET_PIXEL, 5'd16, 3'd3, 0, 0, 0, 0),
      mk_req(REQ_SET_COLUMN, 0, 0, 5'd16, 8'h3C, 0, 0),
      mk_req(REQ_DEVICE, 0, 0, 0, 8'h12, 2'd2, 4'h1),
      mk_req(REQ_COMMIT, 0, 0, 0, 0, 0, 0)});
    wait_idle();
    // zero acts as one chip, seven clamps to the maximum
    write_chain_length(3'd0);
    send_list('{
      mk_req(REQ_COMMIT, 0, 0, 0, 0, 0, 0),
      mk_req(REQ_BROADCAST, 0, 0, 0, 8'h81, 0, 4'h7)});
    wait_idle();
    write_chain_length(3'd7);
    send_list('{mk_req(REQ_COMMIT, 0, 0, 0, 0, 0, 0)});
    wait_idle();
  endtask

  // Receiver holds off while requests keep coming, so full must rise.
  task automatic test_backpressure();
    bit eff;
    write_chain_length(3'd4);
    tx_idle = 1'b0;
    hold_left = 400;
    for (int i = 0; i < 12; i++) begin
      if (i % 4 == 3) send_req(rand_req(REQ_INIT), eff);
      else send_req(rand_req(REQ_COMMIT), eff);
    end
    wait_idle();
  endtask

  task automatic test_random(input logic [2:0] setting, input int count,
                             input bit idle_tx, input bit idle_rx);
    int done_cnt;
    bit eff;
    done_cnt = 0;
    write_chain_length(setting);
    tx_idle = idle_tx;
    rx_idle = idle_rx;
    while (done_cnt < count) begin
      send_req(rand_req(pick_op()), eff);
      if (eff) done_cnt++;
    end
    wait_idle();
  endtask

  // pop side: long hold requested by a test, else random stall bursts while rx_idle is set
  initial begin : pop_driver
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (rx_idle && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin : frame_checker
    chain_frame_t want, got;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        got.word[0] = slot0_word;
        got.word[1] = slot1_word;
        got.word[2] = slot2_word;
        got.word[3] = slot3_word;
        got.last = last_frame;
        if (frame_q.size() == 0) begin
          $error("unexpected frame: %h %h %h %h last %0b",
                 slot0_word, slot1_word, slot2_word, slot3_word, last_frame);
          n_errors++;
        end else begin
          want = frame_q.pop_front();
          n_frames++;
          for (int i = 0; i < 4; i++) begin
            if (got.word[i] !== want.word[i]) begin
              $error("slot%0d_word: expected %04h, got %04h", i, want.word[i], got.word[i]);
              n_errors++;
            end
          end
          if (got.last !== want.last) begin
            $error("last_frame: expected %0b, got %0b", want.last, got.last);
            n_errors++;
          end
        end
      end
    end
  end

  initial begin
    logic [2:0] settings [9];
    settings = '{3'd1, 3'd4, 3'd2, 3'd3, 3'd0, 3'd7, 3'd5, 3'd6, 3'd4};
    chain_setting = 3'd1;
    foreach (column_shadow[i]) column_shadow[i] = 8'h00;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_directed();
    test_backpressure();
    for (int p = 0; p < 8; p++)
      test_random(settings[p], 44, p % 3 != 2, p % 4 != 1);
    // final stretch runs at full rate on both sides
    test_random(settings[8], 44, 1'b0, 1'b0);
    if (frame_q.size() != 0) n_errors++;
    $display("Covered %0d requests (%0d ignored), %0d frames checked, %0d chain settings",
             n_reqs, n_ignored, n_frames, n_settings);
    $display("Input held off by a full block for %0d cycles", n_full_cycles);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
